@@ rtl/core/sfs_pkg.sv @@
// shared widths, op codes and frame table entry type for the sprite frame sequencer
package sfs_pkg;

	localparam int MAX_FRAMES  = 16;
	localparam int FRAME_W     = $clog2(MAX_FRAMES);
	localparam int FRAMES_CAP  = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
	localparam int FRAC_BITS   = 8;

	localparam int OP_W        = 2;
	localparam int TIME_W      = 16;
	localparam int INDEX_W     = 4;
	localparam int DELAY_W     = 16;
	localparam int OPAC_W      = 8;
	localparam int SCALE_W     = 16;
	localparam int COUNT_W     = 5;

	localparam int OPAC_ACC_W  = OPAC_W + FRAC_BITS;
	localparam int SCALE_ACC_W = 24;
	localparam int DIVD_W      = TIME_W + SCALE_W + FRAC_BITS;
	localparam int DIV_CNT_W   = $clog2(DIVD_W);

	localparam int IN_DATA_W   = 88;
	localparam int OUT_DATA_W  = 48;

	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [DELAY_W-1:0]     DEFAULT_DELAY = DELAY_W'(100);
	localparam logic [OPAC_ACC_W-1:0]  OPAC_MAX      = OPAC_ACC_W'(255 << FRAC_BITS);
	localparam logic [SCALE_ACC_W-1:0] SCALE_MAX     = '1;

	localparam logic CFG_FRAME_COUNT = 1'b0;
	localparam logic CFG_ZIGZAG      = 1'b1;

	typedef struct packed {
		logic [SCALE_W-1:0] sc_end;
		logic [SCALE_W-1:0] sc_start;
		logic [OPAC_W-1:0]  op_end;
		logic [OPAC_W-1:0]  op_start;
		logic [DELAY_W-1:0] delay;
	} entry_t;

endpackage

@@ rtl/core/sprite_frame_sequencer.sv @@
// sprite frame sequencer: frame table, delay countdown and bit-serial rate divide
// states: load and unused op go from idle to out, restart via calc, a tick that
// ends its frame via calc and next, other ticks via calc, div (one quotient bit
// per cycle over a 40-bit dividend) and acc; one word in flight: the next input
// word is taken once the result sits in the output register
// reset: arst_n clears frame, direction, delay, accumulators and handshakes at once;
// frame_count returns to 1, zigzag_mode to 0; the frame table is not cleared
module sprite_frame_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// time_step[15:0], entry_index[19:16], entry_delay[35:20],
	// entry_opacity_start[43:36], entry_opacity_end[51:44],
	// entry_scale_start[67:52], entry_scale_end[83:68], zero fill
	input  logic [sfs_pkg::IN_DATA_W-1:0]     s_tdata,
	// op[1:0]
	input  logic [sfs_pkg::OP_W-1:0]          s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// frame_index[3:0], opacity_value[19:4], scale_value[43:20], zero fill
	output logic [sfs_pkg::OUT_DATA_W-1:0]    m_tdata,
	// cycle_ended
	output logic                              m_tlast,
	// frame_changed
	output logic                              m_tuser,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [sfs_pkg::COUNT_W-1:0]       cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_NEXT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam int FW  = sfs_pkg::FRAME_W;
	localparam int DW  = sfs_pkg::DELAY_W;
	localparam int TW  = sfs_pkg::TIME_W;
	localparam int QW  = sfs_pkg::DIVD_W;
	localparam int OAW = sfs_pkg::OPAC_ACC_W;
	localparam int SAW = sfs_pkg::SCALE_ACC_W;
	// full product width of time_step by a difference
	localparam int PW  = sfs_pkg::TIME_W + sfs_pkg::SCALE_W;

	logic [2:0] state_q;

	// configuration registers
	logic [sfs_pkg::COUNT_W-1:0] frame_count_q;
	logic                        zigzag_q;

	// animation state
	logic [FW-1:0]  cur_frame_q;
	logic           dir_back_q;
	logic [DW-1:0]  remaining_q;
	logic [OAW-1:0] opac_acc_q;
	logic [SAW-1:0] scale_acc_q;

	// item being worked on
	logic [sfs_pkg::OP_W-1:0] op_q;
	logic [TW-1:0]            ts_q;
	logic                     ended_q;
	logic                     changed_q;
	logic [FW-1:0]            next_q;
	logic [DW-1:0]            delta_q;

	// frame table, one read port with registered data
	sfs_pkg::entry_t frame_mem [sfs_pkg::MAX_FRAMES];
	sfs_pkg::entry_t rd_q;
	logic [FW-1:0]   rd_addr;

	// serial divider: quotient bits shift in as dividend bits shift out
	logic [QW-1:0]                   op_div_q;
	logic [QW-1:0]                   sc_div_q;
	logic [DW-1:0]                   op_rem_q;
	logic [DW-1:0]                   sc_rem_q;
	logic [DW-1:0]                   divisor_q;
	logic                            op_pos_q;
	logic                            sc_pos_q;
	logic [sfs_pkg::DIV_CNT_W-1:0]   div_cnt_q;

	// output register
	logic                          m_valid_q;
	logic [FW-1:0]                 out_frame_q;
	logic [OAW-1:0]                out_opac_q;
	logic [SAW-1:0]                out_scale_q;
	logic                          out_ended_q;
	logic                          out_changed_q;

	// input unpack
	sfs_pkg::entry_t           in_entry;
	logic [TW-1:0]             in_ts;
	logic [sfs_pkg::INDEX_W-1:0] in_index;
	logic                      in_accept;

	assign in_ts                = s_tdata[15:0];
	assign in_index             = s_tdata[19:16];
	assign in_entry.delay       = (s_tdata[35:20] == '0) ? sfs_pkg::DEFAULT_DELAY : s_tdata[35:20];
	assign in_entry.op_start    = s_tdata[43:36];
	assign in_entry.op_end      = s_tdata[51:44];
	assign in_entry.sc_start    = s_tdata[67:52];
	assign in_entry.sc_end      = s_tdata[83:68];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// frame advance decision, used in the calc state
	logic [sfs_pkg::COUNT_W-1:0] n_use;
	logic [FW-1:0]               last_frame;
	logic [FW-1:0]               eff_frame;
	logic [FW-1:0]               next_frame;
	logic                        next_back;
	logic                        next_ended;
	logic                        expire;

	always_comb begin
		if (frame_count_q == '0) begin
			n_use = sfs_pkg::COUNT_W'(1);
		end else if (frame_count_q > sfs_pkg::COUNT_W'(sfs_pkg::FRAMES_CAP)) begin
			n_use = sfs_pkg::COUNT_W'(sfs_pkg::FRAMES_CAP);
		end else begin
			n_use = frame_count_q;
		end
		last_frame = FW'(n_use - sfs_pkg::COUNT_W'(1));
		// a frame left past the end after frame_count shrank acts as the last one
		eff_frame  = (cur_frame_q > last_frame) ? last_frame : cur_frame_q;
		next_back  = dir_back_q;
		next_ended = 1'b0;
		if (zigzag_q && (last_frame != '0)) begin
			if (!dir_back_q && (eff_frame == last_frame)) begin
				next_back = 1'b1;
			end else if (dir_back_q && (eff_frame == '0)) begin
				next_back  = 1'b0;
				next_ended = 1'b1;
			end
			next_frame = next_back ? (eff_frame - FW'(1)) : (eff_frame + FW'(1));
		end else if (eff_frame == last_frame) begin
			next_frame = '0;
			next_ended = 1'b1;
		end else begin
			next_frame = eff_frame + FW'(1);
		end
		expire = (ts_q >= remaining_q);
	end

	// rate operands: |end - start| and its sign
	logic [sfs_pkg::OPAC_W-1:0]  op_diff;
	logic [sfs_pkg::SCALE_W-1:0] sc_diff;
	logic                        op_pos;
	logic                        sc_pos;

	always_comb begin
		op_pos  = (rd_q.op_end >= rd_q.op_start);
		sc_pos  = (rd_q.sc_end >= rd_q.sc_start);
		op_diff = op_pos ? (rd_q.op_end - rd_q.op_start) : (rd_q.op_start - rd_q.op_end);
		sc_diff = sc_pos ? (rd_q.sc_end - rd_q.sc_start) : (rd_q.sc_start - rd_q.sc_end);
	end

	// table read address: current or restart frame on accept, next frame in calc
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				rd_addr = (s_tuser == sfs_pkg::OP_RESTART) ? '0 : cur_frame_q;
			end
			ST_CALC: begin
				rd_addr = next_frame;
			end
			default: begin
				rd_addr = cur_frame_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept && (s_tuser == sfs_pkg::OP_LOAD)) begin
			frame_mem[in_index[FW-1:0]] <= in_entry;
		end
		rd_q <= frame_mem[rd_addr];
	end

	// one restoring divide step per divider
	logic [DW:0]   op_trial;
	logic [DW:0]   sc_trial;
	logic          op_qbit;
	logic          sc_qbit;
	logic [DW:0]   op_sub;
	logic [DW:0]   sc_sub;

	always_comb begin
		op_trial = {op_rem_q, op_div_q[QW-1]};
		sc_trial = {sc_rem_q, sc_div_q[QW-1]};
		op_sub   = op_trial - {1'b0, divisor_q};
		sc_sub   = sc_trial - {1'b0, divisor_q};
		op_qbit  = (op_trial >= {1'b0, divisor_q});
		sc_qbit  = (sc_trial >= {1'b0, divisor_q});
	end

	// accumulate the signed step with clamping
	logic [QW:0]    op_sum;
	logic [QW:0]    sc_sum;
	logic [OAW-1:0] opac_new;
	logic [SAW-1:0] scale_new;

	always_comb begin
		op_sum = {1'b0, op_div_q} + (QW+1)'(opac_acc_q);
		sc_sum = {1'b0, sc_div_q} + (QW+1)'(scale_acc_q);
		if (op_pos_q) begin
			opac_new = (op_sum > (QW+1)'(sfs_pkg::OPAC_MAX)) ? sfs_pkg::OPAC_MAX : op_sum[OAW-1:0];
		end else begin
			opac_new = (op_div_q > QW'(opac_acc_q)) ? '0 : (opac_acc_q - op_div_q[OAW-1:0]);
		end
		if (sc_pos_q) begin
			scale_new = (sc_sum > (QW+1)'(sfs_pkg::SCALE_MAX)) ? sfs_pkg::SCALE_MAX
			                                                 : sc_sum[SAW-1:0];
		end else begin
			scale_new = (sc_div_q > QW'(scale_acc_q)) ? '0 : (scale_acc_q - sc_div_q[SAW-1:0]);
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= sfs_pkg::COUNT_W'(1);
			zigzag_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfs_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data;
				sfs_pkg::CFG_ZIGZAG:      zigzag_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// divider datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			// register the full products, scaled by the fraction bits, as dividends
			op_div_q  <= QW'({PW'(ts_q) * PW'(op_diff), {sfs_pkg::FRAC_BITS{1'b0}}});
			sc_div_q  <= QW'({PW'(ts_q) * PW'(sc_diff), {sfs_pkg::FRAC_BITS{1'b0}}});
			op_rem_q  <= '0;
			sc_rem_q  <= '0;
			divisor_q <= (rd_q.delay == '0) ? sfs_pkg::DEFAULT_DELAY : rd_q.delay;
			op_pos_q  <= op_pos;
			sc_pos_q  <= sc_pos;
		end else if (state_q == ST_DIV) begin
			op_div_q <= {op_div_q[QW-2:0], op_qbit};
			sc_div_q <= {sc_div_q[QW-2:0], sc_qbit};
			op_rem_q <= op_qbit ? op_sub[DW-1:0] : op_trial[DW-1:0];
			sc_rem_q <= sc_qbit ? sc_sub[DW-1:0] : sc_trial[DW-1:0];
		end
	end

	// item registers and output payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q <= s_tuser;
			ts_q <= in_ts;
		end
		if (state_q == ST_CALC) begin
			next_q  <= next_frame;
			delta_q <= ts_q - remaining_q;
		end
		if ((state_q == ST_OUT) && (!m_valid_q || m_tready)) begin
			out_frame_q   <= cur_frame_q;
			out_opac_q    <= opac_acc_q;
			out_scale_q   <= scale_acc_q;
			out_ended_q   <= ended_q;
			out_changed_q <= changed_q;
		end
	end

	// sequencer and animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_frame_q <= '0;
			dir_back_q  <= 1'b0;
			remaining_q <= '0;
			opac_acc_q  <= '0;
			scale_acc_q <= '0;
			ended_q     <= 1'b0;
			changed_q   <= 1'b0;
			div_cnt_q   <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// output register fills from the out state, empties on a taken word
			if ((state_q == ST_OUT) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						ended_q   <= 1'b0;
						changed_q <= 1'b0;
						// tick and restart wait for the table read, others report at once
						if ((s_tuser == sfs_pkg::OP_TICK) || (s_tuser == sfs_pkg::OP_RESTART)) begin
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CALC: begin
					if (op_q == sfs_pkg::OP_RESTART) begin
						cur_frame_q <= '0;
						dir_back_q  <= 1'b0;
						remaining_q <= rd_q.delay;
						opac_acc_q  <= OAW'({rd_q.op_start, {sfs_pkg::FRAC_BITS{1'b0}}});
						scale_acc_q <= SAW'({rd_q.sc_start, {sfs_pkg::FRAC_BITS{1'b0}}});
						state_q     <= ST_OUT;
					end else if (expire) begin
						// frame ends: the new frame's start values replace any step
						dir_back_q <= next_back;
						ended_q    <= next_ended;
						changed_q  <= (next_frame != cur_frame_q);
						state_q    <= ST_NEXT;
					end else begin
						remaining_q <= remaining_q - ts_q;
						div_cnt_q   <= sfs_pkg::DIV_CNT_W'(QW - 1);
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - sfs_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					opac_acc_q  <= opac_new;
					scale_acc_q <= scale_new;
					state_q     <= ST_OUT;
				end
				ST_NEXT: begin
					// carry the overshoot into the next frame when it fits
					remaining_q <= (rd_q.delay >= delta_q) ? (rd_q.delay - delta_q) : rd_q.delay;
					cur_frame_q <= next_q;
					opac_acc_q  <= OAW'({rd_q.op_start, {sfs_pkg::FRAC_BITS{1'b0}}});
					scale_acc_q <= SAW'({rd_q.sc_start, {sfs_pkg::FRAC_BITS{1'b0}}});
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = sfs_pkg::OUT_DATA_W'({out_scale_q, out_opac_q, out_frame_q});
	assign m_tlast  = out_ended_q;
	assign m_tuser  = out_changed_q;

endmodule
